// ===== rtl/core/hrpc_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the heading controller.
`timescale 1ns / 1ps

package hrpc_pkg;

   // Sizing of the heading path
   localparam int ANGLE_BITS   = 16;
   localparam int QUAT_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int QUAT_FRAC = QUAT_BITS - 2;
   localparam int PROD_W    = 2 * QUAT_BITS;          // one quaternion product
   localparam int SUM_W     = PROD_W + 1;             // sum of two products
   localparam int XY_W      = 2 * QUAT_BITS + 4;      // doubled sum plus CORDIC growth
   localparam int STEP_W    = $clog2(CORDIC_STEPS);
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
   localparam int ATAN_SH    = 32 - ANGLE_BITS;

   // Fixed field widths
   localparam int ACC_W      = 32;
   localparam int RATE_W     = 24;
   localparam int GAIN_W     = 12;
   localparam int TOL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(384);
   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(91);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_ODOM  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef logic [ANGLE_BITS-1:0]     angle_type;
   typedef logic signed [QUAT_BITS-1:0] quat_type;
   typedef logic [ATAN_IDX_W-1:0]     atan_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_YAW,
      ST_TICK,
      ST_PUSH
   } ctl_state_type;

   typedef enum logic [2:0] {
      CD_IDLE,
      CD_MUL,
      CD_SETUP,
      CD_ITER,
      CD_DONE
   } cordic_state_type;

   typedef struct packed {
      logic                       start;
      angle_type                  cur;
      angle_type                  prev;
      logic signed [ACC_W-1:0]    acc;
      logic signed [ACC_W-1:0]    target;
      logic [GAIN_W-1:0]          gain;
      logic [TOL_W-1:0]           tol;
   } tick_cmd_type;

   typedef struct packed {
      logic                       finish;
      logic signed [ACC_W-1:0]    acc;
      logic signed [ACC_W-1:0]    err;
      logic signed [RATE_W-1:0]   rate;
      logic                       done;
   } tick_res_type;

   typedef struct packed {
      logic      done;
      angle_type heading;
   } cordic_res_type;

   // atan(2^-i) in 2^32-per-turn units
   localparam logic [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Round the table entry to nearest at the heading resolution
   function automatic angle_type table_angle(input atan_idx_type idx);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (ATAN_SH - 1));
      return ANGLE_BITS'(t >> ATAN_SH);
   endfunction

endpackage

// ===== rtl/core/hrpc_cordic.sv =====
// Sequenced yaw unit: shared multiplier for the quaternion terms, then vectoring CORDIC.
`timescale 1ns / 1ps

module hrpc_cordic
   import hrpc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  quat_type       quat_w,
   input  quat_type       quat_x,
   input  quat_type       quat_y,
   input  quat_type       quat_z,
   output cordic_res_type res
);

   localparam logic [2:0] MUL_LAST = 3'd4;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
   localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(1) << (2 * QUAT_FRAC);
   localparam angle_type HALF_TURN = angle_type'(1) << (ANGLE_BITS - 1);

   cordic_state_type state_ff, state_in;

   quat_type qw_ff, qx_ff, qy_ff, qz_ff;
   logic [2:0]               phase_ff, phase_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  num_ff, num_in, den_ff, den_in;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   angle_type                z_ff, z_in;
   logic                     zero_ff, zero_in;

   quat_type                 mul_a, mul_b;
   logic signed [XY_W-1:0]   num_x, den_x, xs, ys;
   angle_type                tab;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CD_IDLE:  if (start) state_in = CD_MUL;
         CD_MUL:   if (phase_ff == MUL_LAST) state_in = CD_SETUP;
         CD_SETUP: state_in = CD_ITER;
         CD_ITER:  if (step_ff == LAST_STEP) state_in = CD_DONE;
         CD_DONE:  state_in = CD_IDLE;
         default:  state_in = CD_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      res.done    = (state_ff == CD_DONE);
      res.heading = zero_ff ? '0 : z_ff;
   end

   // Datapath
   always_comb begin
      case (phase_ff)
         3'd0:    begin mul_a = qw_ff; mul_b = qz_ff; end
         3'd1:    begin mul_a = qx_ff; mul_b = qy_ff; end
         3'd2:    begin mul_a = qy_ff; mul_b = qy_ff; end
         default: begin mul_a = qz_ff; mul_b = qz_ff; end
      endcase
      prod_in = mul_a * mul_b;

      phase_in = phase_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      if (state_ff == CD_IDLE) begin
         phase_in = '0;
      end else if (state_ff == CD_MUL) begin
         phase_in = phase_ff + 3'd1;
         case (phase_ff)
            3'd1:    num_in = SUM_W'(prod_ff);
            3'd2:    num_in = num_ff + SUM_W'(prod_ff);
            3'd3:    den_in = SUM_W'(prod_ff);
            3'd4:    den_in = den_ff + SUM_W'(prod_ff);
            default: ;
         endcase
      end

      num_x = XY_W'(num_ff) <<< 1;
      den_x = ONE_XY - (XY_W'(den_ff) <<< 1);
      xs    = x_ff >>> step_ff;
      ys    = y_ff >>> step_ff;
      tab   = table_angle(atan_idx_type'(step_ff));

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      step_in = step_ff;
      if (state_ff == CD_SETUP) begin
         zero_in = (num_x == '0) && (den_x == '0);
         step_in = '0;
         if (den_x[XY_W-1]) begin
            x_in = -den_x;
            y_in = -num_x;
            z_in = HALF_TURN;
         end else begin
            x_in = den_x;
            y_in = num_x;
            z_in = '0;
         end
      end else if (state_ff == CD_ITER) begin
         step_in = step_ff + STEP_W'(1);
         if (!y_ff[XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + tab;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - tab;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == CD_IDLE) begin
         qw_ff <= quat_w;
         qx_ff <= quat_x;
         qy_ff <= quat_y;
         qz_ff <= quat_z;
      end
      phase_ff <= phase_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zero_ff  <= zero_in;
      step_ff  <= step_in;
   end

endmodule

// ===== rtl/core/hrpc_tick.sv =====
// Control tick datapath: unwrap and accumulate, error, gain multiply, saturate.
`timescale 1ns / 1ps

module hrpc_tick
   import hrpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tick_cmd_type cmd,
   output tick_res_type res
);

   localparam int TICK_STAGES = 5;
   localparam int MUL_W       = GAIN_W + 1 + ACC_W;
   localparam int FRAC_SH     = 8;

   logic [TICK_STAGES-1:0]   stage_ff, stage_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, err_ff, err_in;
   logic                     done_ff, done_in;
   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;

   angle_type                diff;
   logic signed [ACC_W:0]    acc_sum, err_sum;
   logic [ACC_W-1:0]         mag;
   logic [MUL_W-1:ACC_W-1]   prod_hi;

   always_comb begin
      stage_in = cmd.start ? TICK_STAGES'(1) : (stage_ff << 1);

      // Wrapped heading change, read as signed
      diff    = cmd.cur - cmd.prev;
      acc_sum = {{(ACC_W+1-ANGLE_BITS){diff[ANGLE_BITS-1]}}, diff}
              + {cmd.acc[ACC_W-1], cmd.acc};
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end

      err_sum = {cmd.target[ACC_W-1], cmd.target} - {acc_ff[ACC_W-1], acc_ff};
      if (err_sum[ACC_W] != err_sum[ACC_W-1]) begin
         err_in = err_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         err_in = err_sum[ACC_W-1:0];
      end

      mag     = err_ff[ACC_W-1] ? (~err_ff + ACC_W'(1)) : err_ff;
      done_in = mag < {{(ACC_W-TOL_W){1'b0}}, cmd.tol};
      prod_in = $signed({1'b0, cmd.gain}) * err_ff;

      prod_hi = prod_ff[MUL_W-1:ACC_W-1];
      if (done_ff) begin
         rate_in = '0;
      end else if ((&prod_hi) || !(|prod_hi)) begin
         rate_in = prod_ff[ACC_W-1:FRAC_SH];
      end else begin
         rate_in = prod_ff[MUL_W-1] ? RATE_MIN : RATE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ff[0]) acc_ff <= acc_in;
      if (stage_ff[1]) err_ff <= err_in;
      if (stage_ff[2]) begin
         done_ff <= done_in;
         prod_ff <= prod_in;
      end
      if (stage_ff[3]) rate_ff <= rate_in;
   end

   assign res.finish = stage_ff[TICK_STAGES-1];
   assign res.acc    = acc_ff;
   assign res.err    = err_ff;
   assign res.rate   = rate_ff;
   assign res.done   = done_ff;

endmodule

// ===== rtl/core/heading_rotation_p_controller.sv =====
// Top level of the proportional heading controller: sequencer, state, csr and result register.
`timescale 1ns / 1ps

// Proportional heading controller. Odometry transactions (kind 1) carry a Q1.14
// quaternion; the block derives yaw with a vectoring CORDIC and stores it as a
// binary angle, 2^ANGLE_BITS units per turn. A start transaction (kind 0) clears
// the accumulated rotation, latches the current heading as the reference and arms
// the controller. A tick (kind 2) while armed adds the wrapped heading change to a
// saturating 32-bit accumulator and returns one result: remaining angle, rate
// command (gain Q4.8 times error, saturated to 24 bits) and done; done returns a
// zero rate and disarms. Ticks while disarmed and kind 3 are dropped silently.
// One transaction is processed at a time and req_stall is high while it runs.
// An odometry transaction passes through the accept cycle, four products through
// the single shared 16x16 multiplier, an accumulate and a setup step, the CORDIC
// iterations and a handoff step. A tick passes through the accept cycle, the
// five-stage tick datapath and the push into the result register, which waits if
// the previous result is still stalled there. Start and dropped transactions
// complete on acceptance. The result register lets the next transaction in while
// a result waits to be taken. Configuration is written through
// csr_we / csr_index / csr_wdata and must only change while the block is idle.

module heading_rotation_p_controller
   import hrpc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic signed [QUAT_BITS-1:0] req_quat_w,
   input  logic signed [QUAT_BITS-1:0] req_quat_x,
   input  logic signed [QUAT_BITS-1:0] req_quat_y,
   input  logic signed [QUAT_BITS-1:0] req_quat_z,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [ACC_W-1:0]     rsp_angle_to_go,
   output logic signed [RATE_W-1:0]    rsp_angular_rate,
   output logic                        rsp_done_res
);

   ctl_state_type state_ff, state_in;

   // Configuration registers
   logic signed [ACC_W-1:0] target_ff, target_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [TOL_W-1:0]        tol_ff, tol_in;

   // Controller state
   angle_type               cur_ff, cur_in;
   angle_type               prev_ff, prev_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    running_ff, running_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]  rsp_err_ff;
   logic signed [RATE_W-1:0] rsp_rate_ff;
   logic                     rsp_done_ff;

   logic accept, cordic_start, tick_start, start_rot, push;

   cordic_res_type cres;
   tick_cmd_type   tcmd;
   tick_res_type   tres;

   hrpc_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .quat_w (req_quat_w),
      .quat_x (req_quat_x),
      .quat_y (req_quat_y),
      .quat_z (req_quat_z),
      .res    (cres)
   );

   assign tcmd.start  = tick_start;
   assign tcmd.cur    = cur_ff;
   assign tcmd.prev   = prev_ff;
   assign tcmd.acc    = acc_ff;
   assign tcmd.target = target_ff;
   assign tcmd.gain   = gain_ff;
   assign tcmd.tol    = tol_ff;

   hrpc_tick u_tick (
      .clock (clock),
      .reset (reset),
      .cmd   (tcmd),
      .res   (tres)
   );

   // Sequencer outputs: decode the accepted transaction, push when the result slot frees
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      accept       = req_valid && (state_ff == ST_IDLE);
      cordic_start = 1'b0;
      tick_start   = 1'b0;
      start_rot    = 1'b0;
      if (accept) begin
         case (req_kind)
            KIND_START: start_rot    = 1'b1;
            KIND_ODOM:  cordic_start = 1'b1;
            KIND_TICK:  tick_start   = running_ff;
            default:    ;
         endcase
      end
      push = (state_ff == ST_PUSH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cordic_start) begin
               state_in = ST_YAW;
            end else if (tick_start) begin
               state_in = ST_TICK;
            end
         end
         ST_YAW:  if (cres.done) state_in = ST_IDLE;
         ST_TICK: if (tres.finish) state_in = ST_PUSH;
         ST_PUSH: if (push) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Register updates
   always_comb begin
      target_in = target_ff;
      gain_in   = gain_ff;
      tol_in    = tol_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TARGET: target_in = csr_wdata;
            CSR_GAIN:   gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_TOL:    tol_in    = csr_wdata[TOL_W-1:0];
            default:    ;
         endcase
      end

      cur_in     = (state_ff == ST_YAW && cres.done) ? cres.heading : cur_ff;
      prev_in    = prev_ff;
      acc_in     = acc_ff;
      running_in = running_ff;
      if (start_rot) begin
         // restart from the current heading
         prev_in    = cur_ff;
         acc_in     = '0;
         running_in = 1'b1;
      end else if (push) begin
         prev_in    = cur_ff;
         acc_in     = tres.acc;
         running_in = !tres.done;
      end

      // hold the result while stalled, drop it once taken
      rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         gain_ff      <= GAIN_RESET;
         tol_ff       <= TOL_RESET;
         cur_ff       <= '0;
         prev_ff      <= '0;
         acc_ff       <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         gain_ff      <= gain_in;
         tol_ff       <= tol_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         acc_ff       <= acc_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_err_ff  <= tres.err;
         rsp_rate_ff <= tres.rate;
         rsp_done_ff <= tres.done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle_to_go  = rsp_err_ff;
   assign rsp_angular_rate = rsp_rate_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

// ===== rtl/core/hrpc_checker.sv =====
// Port-level checker for the heading controller, bound to the top level.
`timescale 1ns / 1ps

module hrpc_checker
   import hrpc_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [1:0]                  req_kind,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [ACC_W-1:0]     rsp_angle_to_go,
   input logic signed [RATE_W-1:0]    rsp_angular_rate,
   input logic                        rsp_done_res
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Done carries a zero rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_angular_rate == '0)
      else $error("nonzero rate with done");

   // A negative error never commands a positive rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res && rsp_angle_to_go[ACC_W-1]
         |-> rsp_angular_rate[RATE_W-1] || rsp_angular_rate == '0)
      else $error("rate sign disagrees with error");

   // An accepted odometry transaction stalls the input while the yaw unit runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_ODOM |=> req_stall)
      else $error("odometry transaction did not stall the input");

endmodule

bind heading_rotation_p_controller hrpc_checker u_hrpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_angle_to_go  (rsp_angle_to_go),
   .rsp_angular_rate (rsp_angular_rate),
   .rsp_done_res     (rsp_done_res)
);

// ===== bench/hrpc_rate_checker.sv =====
// Checker for the heading controller: tracks heading state, predicts rate commands, compares results.
`timescale 1ns / 1ps

module hrpc_rate_checker
   import hrpc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,

   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic signed [QUAT_BITS-1:0] req_quat_w,
   input  logic signed [QUAT_BITS-1:0] req_quat_x,
   input  logic signed [QUAT_BITS-1:0] req_quat_y,
   input  logic signed [QUAT_BITS-1:0] req_quat_z,

   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [ACC_W-1:0]     rsp_angle_to_go,
   input  logic signed [RATE_W-1:0]    rsp_angular_rate,
   input  logic                        rsp_done_res,

   output int                          mismatches,
   output int                          outstanding
);

   typedef struct packed {
      logic signed [ACC_W-1:0]  remaining;
      logic signed [RATE_W-1:0] rate;
      logic                     done;
   } rate_cmd_type;

   rate_cmd_type rate_cmds_due [$];

   // Settings as the block should hold them
   logic signed [ACC_W-1:0] goal_angle;
   logic [GAIN_W-1:0]       gain_q48;
   logic [TOL_W-1:0]        tolerance;

   // Heading and rotation state
   angle_type               heading_now;
   angle_type               heading_ref;
   logic signed [ACC_W-1:0] turned;
   logic                    armed;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // atan(2^-i), one turn = 2^32, rounded to nearest at the heading width
   function automatic angle_type atan_step(input int i);
      logic [32:0] full;
      case (i)
         0:  full = 33'h20000000;
         1:  full = 33'h12E4051E;
         2:  full = 33'h09FB385B;
         3:  full = 33'h051111D4;
         4:  full = 33'h028B0D43;
         5:  full = 33'h0145D7E1;
         6:  full = 33'h00A2F61E;
         7:  full = 33'h00517C55;
         8:  full = 33'h0028BE53;
         9:  full = 33'h00145F2F;
         10: full = 33'h000A2F98;
         11: full = 33'h000517CC;
         12: full = 33'h00028BE6;
         13: full = 33'h000145F3;
         14: full = 33'h0000A2FA;
         15: full = 33'h0000517D;
         16: full = 33'h000028BE;
         17: full = 33'h0000145F;
         18: full = 33'h00000A30;
         19: full = 33'h00000518;
         20: full = 33'h0000028C;
         21: full = 33'h00000146;
         22: full = 33'h000000A3;
         23: full = 33'h00000051;
         default: full = 33'h0;
      endcase
      full = full + (33'd1 << (31 - ANGLE_BITS));
      return angle_type'(full >> (32 - ANGLE_BITS));
   endfunction

   always @(posedge clock) begin : watch
      longint       num, den, vx, vy, xs, ys;
      longint       delta, acc_next, err, mag, rate;
      angle_type    ang, diff;
      rate_cmd_type cmd;
      int           i;

      if (reset) begin
         goal_angle  = '0;
         gain_q48    = GAIN_RESET;
         tolerance   = TOL_RESET;
         heading_now = '0;
         heading_ref = '0;
         turned      = '0;
         armed       = 1'b0;
         mismatches  = 0;
         rate_cmds_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET: goal_angle = csr_wdata;
               CSR_GAIN:   gain_q48   = csr_wdata[GAIN_W-1:0];
               CSR_TOL:    tolerance  = csr_wdata[TOL_W-1:0];
               default:    ;
            endcase
         end

         // Compare a taken result against the oldest command due
         if (rsp_valid && !rsp_stall) begin
            if (rate_cmds_due.size() == 0) begin
               $error("result with nothing pending: angle_to_go %0d angular_rate %0d",
                      rsp_angle_to_go, rsp_angular_rate);
               mismatches++;
            end else begin
               cmd = rate_cmds_due.pop_front();
               if (rsp_angle_to_go !== cmd.remaining) begin
                  $error("angle_to_go: expected %0d, got %0d",
                         cmd.remaining, rsp_angle_to_go);
                  mismatches++;
               end
               if (rsp_angular_rate !== cmd.rate) begin
                  $error("angular_rate: expected %0d, got %0d", cmd.rate, rsp_angular_rate);
                  mismatches++;
               end
               if (rsp_done_res !== cmd.done) begin
                  $error("done_res: expected %0d, got %0d", cmd.done, rsp_done_res);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_START: begin
                  turned      = '0;
                  heading_ref = heading_now;
                  armed       = 1'b1;
               end
               KIND_ODOM: begin
                  num = 2 * (longint'(req_quat_w) * longint'(req_quat_z)
                           + longint'(req_quat_x) * longint'(req_quat_y));
                  den = (longint'(1) <<< (2 * QUAT_FRAC))
                        - 2 * (longint'(req_quat_y) * longint'(req_quat_y)
                             + longint'(req_quat_z) * longint'(req_quat_z));
                  vx  = den;
                  vy  = num;
                  ang = '0;
                  if (vx != 0 || vy != 0) begin
                     // fold the left half plane over, starting at a half turn
                     if (vx < 0) begin
                        vx  = -vx;
                        vy  = -vy;
                        ang = {1'b1, {(ANGLE_BITS-1){1'b0}}};
                     end
                     for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                        xs = vx >>> i;
                        ys = vy >>> i;
                        if (vy >= 0) begin
                           vx  = vx + ys;
                           vy  = vy - xs;
                           ang = ang + atan_step(i);
                        end else begin
                           vx  = vx - ys;
                           vy  = vy + xs;
                           ang = ang - atan_step(i);
                        end
                     end
                  end
                  heading_now = ang;
               end
               KIND_TICK: begin
                  if (armed) begin
                     diff        = heading_now - heading_ref;
                     delta       = longint'(signed'(diff));
                     acc_next    = clamp(longint'(turned) + delta,
                                         longint'(ACC_MIN), longint'(ACC_MAX));
                     turned      = acc_next[ACC_W-1:0];
                     heading_ref = heading_now;
                     err         = clamp(longint'(goal_angle) - acc_next,
                                         longint'(ACC_MIN), longint'(ACC_MAX));
                     mag         = (err < 0) ? -err : err;
                     rate        = 0;
                     cmd.done    = 1'b0;
                     if (mag < longint'(tolerance)) begin
                        cmd.done = 1'b1;
                        armed    = 1'b0;
                     end else begin
                        rate = clamp((longint'(gain_q48) * err) >>> 8,
                                     longint'(RATE_MIN), longint'(RATE_MAX));
                     end
                     cmd.remaining = err[ACC_W-1:0];
                     cmd.rate      = rate[RATE_W-1:0];
                     rate_cmds_due.push_back(cmd);
                  end
               end
               default: ;
            endcase
         end
      end
      outstanding = rate_cmds_due.size();
   end

endmodule

// ===== bench/heading_rotation_p_controller_tb.sv =====
// Testbench top for the heading controller: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module heading_rotation_p_controller_tb;
   import hrpc_pkg::*;

   localparam int ITEM_TARGET    = 1350;
   localparam int SETTLE_CYCLES  = 40;    // covers an odometry transaction still in flight
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   // kind code the block must drop, and the csr index past the register list
   localparam logic [1:0]           KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = CSR_IDX_W'(3);

   logic clock = 1'b0;
   logic reset;

   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   logic                        req_valid;
   logic                        req_stall;
   logic [1:0]                  req_kind;
   logic signed [QUAT_BITS-1:0] req_quat_w;
   logic signed [QUAT_BITS-1:0] req_quat_x;
   logic signed [QUAT_BITS-1:0] req_quat_y;
   logic signed [QUAT_BITS-1:0] req_quat_z;

   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [ACC_W-1:0]     rsp_angle_to_go;
   logic signed [RATE_W-1:0]    rsp_angular_rate;
   logic                        rsp_done_res;

   int mismatches;
   int outstanding;

   // Stimulus controls shared with the receiver process
   logic calm_tail = 1'b0;     // no idling on either side once set
   int   gap_pct   = 25;       // chance of a sender gap before a transaction
   int   holds_requested = 0;  // bump to ask the receiver for one long hold-off
   int   items_counted   = 0;
   int   stuck_cycles;

   // Last odometry quaternion, reused for repeats and small nudges
   quat_type last_w = 16'sd16384;
   quat_type last_x = '0;
   quat_type last_y = '0;
   quat_type last_z = '0;

   always #5 clock = ~clock;

   heading_rotation_p_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_quat_w       (req_quat_w),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle_to_go  (rsp_angle_to_go),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_done_res     (rsp_done_res)
   );

   hrpc_rate_checker rate_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_quat_w       (req_quat_w),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle_to_go  (rsp_angle_to_go),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_done_res     (rsp_done_res),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   function automatic quat_type clip_quat(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return quat_type'(v);
   endfunction

   // Offer one transaction and hold it until the block takes it. A random gap
   // may come first; otherwise valid stays high straight into the next one.
   task automatic send_item(input logic [1:0] kind, input quat_type w, input quat_type x,
                            input quat_type y, input quat_type z);
      if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      do @(posedge clock); while (req_stall);
      if (kind != KIND_UNUSED) items_counted++;
   endtask

   // Start, tick or dropped kind: the quaternion is junk the block must ignore
   task automatic send_ctl(input logic [1:0] kind);
      send_item(kind, quat_type'($urandom), quat_type'($urandom),
                quat_type'($urandom), quat_type'($urandom));
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write all three registers back to back, junk in the unused upper bits,
   // plus a write to the spare index that the block must drop
   task automatic load_settings(input logic signed [ACC_W-1:0] target,
                                input logic [GAIN_W-1:0] gain, input logic [TOL_W-1:0] tol);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET;
      csr_wdata <= target;
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= {(CSR_DATA_W-GAIN_W)'($urandom), gain};
      @(posedge clock);
      csr_index <= CSR_TOL;
      csr_wdata <= {(CSR_DATA_W-TOL_W)'($urandom), tol};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Let the block go idle, then change settings
   task automatic reconfigure(input logic signed [ACC_W-1:0] target,
                              input logic [GAIN_W-1:0] gain, input logic [TOL_W-1:0] tol);
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      load_settings(target, gain, tol);
   endtask

   // Receiver: random stall bursts and ready stretches, one long hold-off on request,
   // always ready in the calm tail
   initial begin : receiver
      int served;
      served = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_requested != served) begin
            served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("heading_rotation_p_controller verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      logic signed [ACC_W-1:0] target;
      logic [GAIN_W-1:0]       gain;
      logic [TOL_W-1:0]        tol;
      quat_type                w, x, y, z;
      int                      phase, phase_len, k, roll;

      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_TARGET;
      csr_wdata  <= '0;
      req_valid  <= 1'b0;
      req_kind   <= KIND_START;
      req_quat_w <= '0;
      req_quat_x <= '0;
      req_quat_y <= '0;
      req_quat_z <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings. Tick while idle, dropped kind, zero vector,
      // then a start and a tick that lands inside tolerance at once.
      send_ctl(KIND_TICK);
      send_ctl(KIND_UNUSED);
      send_item(KIND_ODOM, 16'sd1000, -16'sd1000, 16'sd8192, 16'sd8192);
      send_ctl(KIND_START);
      send_ctl(KIND_TICK);
      send_ctl(KIND_TICK);

      // Directed: large goal, full gain, zero tolerance. Walk through the
      // quadrants, the field extremes, a zero denominator and a restart.
      reconfigure(32'sd200000, 12'd4095, 16'd0);
      send_ctl(KIND_START);
      send_item(KIND_ODOM, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
      send_ctl(KIND_TICK);
      send_item(KIND_ODOM, 16'sd32767, 16'sd0, 16'sd0, 16'sd0);
      send_ctl(KIND_TICK);
      send_item(KIND_ODOM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_ctl(KIND_TICK);
      send_item(KIND_ODOM, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_ctl(KIND_TICK);
      send_item(KIND_ODOM, 16'sd1000, 16'sd1000, 16'sd8192, 16'sd8192);
      send_ctl(KIND_TICK);
      send_ctl(KIND_START);
      send_ctl(KIND_TICK);
      send_item(KIND_ODOM, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384);
      send_ctl(KIND_UNUSED);
      send_ctl(KIND_TICK);

      // Directed: most negative goal; a wide heading swing drives the rate to its
      // negative limit
      reconfigure(ACC_MIN, 12'd4095, 16'hFFFF);
      send_ctl(KIND_START);
      send_item(KIND_ODOM, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
      send_ctl(KIND_TICK);

      // Directed: most positive goal with zero gain, swinging the other way
      reconfigure(ACC_MAX, 12'd0, 16'hFFFF);
      send_ctl(KIND_START);
      send_item(KIND_ODOM, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384);
      send_ctl(KIND_TICK);

      // Random phases, each with its own settings and a rotation started at its head
      items_counted = 0;
      phase = 0;
      while (items_counted < ITEM_TARGET) begin
         calm_tail = (items_counted + 160 >= ITEM_TARGET);

         case ($urandom_range(0, 5))
            0:       target = $urandom;
            1:       target = $urandom_range(0, 1) ? ACC_MAX : ACC_MIN;
            5:       target = '0;
            default: target = int'($urandom_range(0, 140000)) - 70000;
         endcase
         case ($urandom_range(0, 3))
            0:       gain = '0;
            1:       gain = '1;
            default: gain = GAIN_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       tol = '0;
            1:       tol = '1;
            2:       tol = TOL_W'($urandom);
            default: tol = TOL_W'($urandom_range(0, 4000));
         endcase
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 40;
         endcase

         // Fill-up phase: a goal that never completes, so every tick makes a result
         if (phase == 2) begin
            target = ACC_MAX;
            tol    = '0;
         end
         reconfigure(target, gain, tol);
         send_ctl(KIND_START);

         // Hold the receiver off and keep offering ticks back to back until the
         // result register fills and the block stalls its input
         if (phase == 2) begin
            gap_pct = 0;
            holds_requested++;
            repeat (20) send_ctl(KIND_TICK);
         end

         phase_len = $urandom_range(60, 140);
         for (k = 0; k < phase_len; k++) begin
            // Pause the sender until every expected result is back
            if (phase == 4 && k == phase_len / 2) await_results();

            roll = $urandom_range(0, 99);
            if (roll < 7) begin
               send_ctl(KIND_START);
            end else if (roll < 10) begin
               send_ctl(KIND_UNUSED);
            end else if (roll < 52) begin
               roll = $urandom_range(0, 99);
               if (roll < 20) begin
                  // repeat the last pose: zero heading change
                  w = last_w; x = last_x; y = last_y; z = last_z;
               end else if (roll < 45) begin
                  // pure yaw rotation
                  w = quat_type'(int'($urandom_range(0, 32768)) - 16384);
                  x = '0;
                  y = '0;
                  z = quat_type'(int'($urandom_range(0, 32768)) - 16384);
               end else if (roll < 62) begin
                  // nudge the last pose: small heading changes that can reach the goal
                  w = clip_quat(int'(last_w) + int'($urandom_range(0, 1200)) - 600);
                  x = last_x;
                  y = last_y;
                  z = clip_quat(int'(last_z) + int'($urandom_range(0, 1200)) - 600);
               end else if (roll < 88) begin
                  w = quat_type'($urandom);
                  x = quat_type'($urandom);
                  y = quat_type'($urandom);
                  z = quat_type'($urandom);
               end else begin
                  case ($urandom_range(0, 4))
                     0: begin
                        // zero vector: numerator and denominator both vanish
                        w = quat_type'($urandom_range(0, 32767));
                        x = -w;
                        y = 16'sd8192;
                        z = 16'sd8192;
                     end
                     1: begin
                        // zero denominator with a positive numerator
                        w = quat_type'($urandom_range(1, 16384));
                        x = quat_type'($urandom_range(1, 16384));
                        y = 16'sd8192;
                        z = 16'sd8192;
                     end
                     2: begin
                        w = 16'sh8000; x = 16'sh8000; y = 16'sh8000; z = 16'sh8000;
                     end
                     3: begin
                        w = 16'sh7FFF; x = 16'sh7FFF; y = 16'sh7FFF; z = 16'sh7FFF;
                     end
                     default: begin
                        // negative denominator: left half plane
                        w = quat_type'($urandom);
                        x = quat_type'($urandom);
                        y = quat_type'($urandom_range(16384, 32767));
                        z = quat_type'($urandom_range(16384, 32767));
                     end
                  endcase
               end
               last_w = w; last_x = x; last_y = y; last_z = z;
               send_item(KIND_ODOM, w, x, y, z);
            end else begin
               send_ctl(KIND_TICK);
            end
         end
         phase++;
      end

      // Drain, then give late or stray results time to show up
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("heading_rotation_p_controller verification clean");
      end else begin
         $display("heading_rotation_p_controller verification failed");
      end
      $finish;
   end

endmodule

// ===== heading_rotation_p_controller.f =====
rtl/core/hrpc_pkg.sv
rtl/core/hrpc_cordic.sv
rtl/core/hrpc_tick.sv
rtl/core/heading_rotation_p_controller.sv
rtl/core/hrpc_checker.sv
bench/hrpc_rate_checker.sv
bench/heading_rotation_p_controller_tb.sv
